[design/rgbhsv_pkg.sv]
// Shared types and constants for the RGB to HSV pixel converter.
`default_nettype none

package rgbhsv_pkg;

   // Hue is kept in degrees times 64.
   localparam logic [11:0] HUE_SIXTY    = 12'd3840;
   localparam logic [14:0] HUE_SECTOR_G = 15'd7680;
   localparam logic [14:0] HUE_SECTOR_B = 15'd15360;
   localparam logic [14:0] HUE_FULL     = 15'd23040;
   localparam logic [15:0] SAT_ONE      = 16'd32768;

   // Both dividers produce one quotient bit per pipeline step.
   localparam int DIV_STEPS = 16;

   // Work item as it travels from the front end through the divider pipeline.
   // The *_q fields start out holding the dividend bits still to be shifted in
   // and end up holding the quotient.
   typedef struct packed {
      logic [7:0]  hue_div;
      logic [7:0]  hue_rem;
      logic [15:0] hue_q;
      logic [7:0]  sat_div;
      logic [7:0]  sat_rem;
      logic [15:0] sat_q;
      logic [14:0] hue_base;
      logic        hue_neg;
      logic        hue_floor;
      logic        grey;
   } div_state_type;

endpackage

`default_nettype wire

[design/rgbhsv_front.sv]
// Front end: finds max and min of the pixel and sets up both divisions.
`default_nettype none

module rgbhsv_front (
   input  wire logic [7:0]                  red,
   input  wire logic [7:0]                  green,
   input  wire logic [7:0]                  blue,
   input  wire logic                        wrap_negative_hue,
   output      rgbhsv_pkg::div_state_type   work
);

   logic [7:0]  max_val;
   logic [7:0]  min_val;
   logic [7:0]  delta;
   logic        red_sector;
   logic        green_sector;
   logic [8:0]  diff;
   logic [7:0]  diff_abs;
   logic [19:0] hue_num;

   always_comb begin
      max_val = red;
      if (green > max_val) max_val = green;
      if (blue > max_val) max_val = blue;
      min_val = red;
      if (green < min_val) min_val = green;
      if (blue < min_val) min_val = blue;
   end

   assign delta        = max_val - min_val;
   assign red_sector   = (red == max_val);
   assign green_sector = !red_sector && (green == max_val);

   always_comb begin
      if (red_sector) begin
         diff = {1'b0, green} - {1'b0, blue};
      end else if (green_sector) begin
         diff = {1'b0, blue} - {1'b0, red};
      end else begin
         diff = {1'b0, red} - {1'b0, green};
      end
   end

   // The channel difference never exceeds delta, so its magnitude fits 8 bits.
   assign diff_abs = diff[8] ? 8'(-diff) : diff[7:0];
   assign hue_num  = 20'(diff_abs) * 20'(rgbhsv_pkg::HUE_SIXTY);

   always_comb begin
      work.hue_div   = delta;
      work.hue_rem   = {4'b0, hue_num[19:16]};
      work.hue_q     = hue_num[15:0];
      work.sat_div   = max_val;
      work.sat_rem   = {1'b0, delta[7:1]};
      work.sat_q     = {delta[0], 15'b0};
      work.hue_neg   = diff[8];
      work.grey      = (delta == 8'd0);
      // Green and blue sectors, and a wrapped red sector, have a positive
      // numerator, so truncation there is a floor of the signed fraction.
      work.hue_floor = !red_sector || wrap_negative_hue;
      if (red_sector) begin
         work.hue_base = (diff[8] && wrap_negative_hue) ? rgbhsv_pkg::HUE_FULL : 15'd0;
      end else if (green_sector) begin
         work.hue_base = rgbhsv_pkg::HUE_SECTOR_G;
      end else begin
         work.hue_base = rgbhsv_pkg::HUE_SECTOR_B;
      end
   end

endmodule

`default_nettype wire

[design/rgbhsv_queue.sv]
// Small queue that decouples the front end from the divider pipeline.
`default_nettype none

module rgbhsv_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire rgbhsv_pkg::div_state_type   push_data,
   output      logic                        full,
   input  wire logic                        pop,
   output      logic                        head_valid,
   output      rgbhsv_pkg::div_state_type   head_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rgbhsv_pkg::div_state_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[design/rgbhsv_div_stage.sv]
// One restoring-division step for both the hue and saturation dividers.
`default_nettype none

module rgbhsv_div_stage (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic                        in_valid,
   input  wire rgbhsv_pkg::div_state_type   in_state,
   output      logic                        out_valid_ff,
   output      rgbhsv_pkg::div_state_type   out_state_ff
);

   rgbhsv_pkg::div_state_type state_in;
   logic [8:0] hue_trial;
   logic [8:0] sat_trial;
   logic       hue_bit;
   logic       sat_bit;

   // Shift the next dividend bit into the remainder and subtract the divisor
   // when it fits; the quotient bit enters at the bottom of the *_q register that held the dividend bits.
   assign hue_trial = {in_state.hue_rem, in_state.hue_q[15]};
   assign sat_trial = {in_state.sat_rem, in_state.sat_q[15]};
   assign hue_bit   = (hue_trial >= {1'b0, in_state.hue_div});
   assign sat_bit   = (sat_trial >= {1'b0, in_state.sat_div});

   always_comb begin
      state_in         = in_state;
      state_in.hue_rem = hue_bit ? 8'(hue_trial - {1'b0, in_state.hue_div}) : hue_trial[7:0];
      state_in.hue_q   = {in_state.hue_q[14:0], hue_bit};
      state_in.sat_rem = sat_bit ? 8'(sat_trial - {1'b0, in_state.sat_div}) : sat_trial[7:0];
      state_in.sat_q   = {in_state.sat_q[14:0], sat_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[design/rgbhsv_back.sv]
// Back end: divider pipeline, hue correction and the result register.
`default_nettype none

module rgbhsv_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        work_valid,
   input  wire rgbhsv_pkg::div_state_type   work,
   output      logic                        work_take,
   output      logic                        rsp_empty,
   input  wire logic                        rsp_pop,
   output      logic signed [15:0]          rsp_hue,
   output      logic [15:0]                 rsp_saturation,
   output      logic [7:0]                  rsp_value
);

   localparam int STEPS = rgbhsv_pkg::DIV_STEPS;

   logic                      advance;
   logic                      stage_valid [STEPS+1];
   rgbhsv_pkg::div_state_type stage_state [STEPS+1];
   rgbhsv_pkg::div_state_type last;
   logic [16:0]               hue_sum;
   logic                      round_down;
   logic                      out_valid_ff;
   logic signed [15:0]        hue_ff, hue_in;
   logic [15:0]               sat_ff, sat_in;
   logic [7:0]                value_ff;

   // The whole pipeline moves together whenever the result register can take.
   assign advance   = !out_valid_ff || rsp_pop;
   assign work_take = advance;

   assign stage_valid[0] = work_valid;
   assign stage_state[0] = work;

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      rgbhsv_div_stage u_step (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .in_valid     (stage_valid[i]),
         .in_state     (stage_state[i]),
         .out_valid_ff (stage_valid[i+1]),
         .out_state_ff (stage_state[i+1])
      );
   end

   assign last       = stage_state[STEPS];
   assign round_down = last.hue_floor && (last.hue_rem != 8'd0);

   always_comb begin
      if (last.hue_neg) begin
         hue_sum = {2'b0, last.hue_base} - {1'b0, last.hue_q} - 17'(round_down);
      end else begin
         hue_sum = {2'b0, last.hue_base} + {1'b0, last.hue_q};
      end
      hue_in = last.grey ? 16'sd0 : $signed(hue_sum[15:0]);
      sat_in = last.grey ? 16'd0 : last.sat_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= stage_valid[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         value_ff <= last.sat_div;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_value      = value_ff;

endmodule

`default_nettype wire

[design/rgb_to_hsv_pixel.sv]
// Top level of the RGB to HSV pixel converter.
// Each beat passes the queue, 16-step pipelined restoring dividers and result register.
// Throughput: one pixel per cycle while the result side is not stalled.
// The intake queue holds up to QUEUE_DEPTH pixels while the result side is stalled.
// Reset (synchronous, active high) empties the queue and pipeline and sets wrap mode to 1.
`default_nettype none

module rgb_to_hsv_pixel #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output      logic               req_full,
   input  wire logic [7:0]         req_red,
   input  wire logic [7:0]         req_green,
   input  wire logic [7:0]         req_blue,
   output      logic               rsp_empty,
   input  wire logic               rsp_pop,
   output      logic signed [15:0] rsp_hue,
   output      logic [15:0]        rsp_saturation,
   output      logic [7:0]         rsp_value,
   input  wire logic               csr_we,
   input  wire logic               csr_wdata
);

   // The wrap mode register decides whether a negative red-sector hue gets a
   // full turn added. It is sampled by the front end as each pixel beat enters;
   // the user must rewrite it only while the block is idle; the block does not enforce this.
   logic wrap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff <= 1'b1;
      end else if (csr_we) begin
         wrap_ff <= csr_wdata;
      end
   end

   // The front end is purely combinational: it finds the largest and smallest
   // channel, picks the hue sector, and prepares the dividend and divisor for
   // both the hue fraction and the saturation ratio.
   rgbhsv_pkg::div_state_type front_work;

   rgbhsv_front u_front (
      .red               (req_red),
      .green             (req_green),
      .blue              (req_blue),
      .wrap_negative_hue (wrap_ff),
      .work              (front_work)
   );

   // The queue lets the front end keep accepting beats for a short while when
   // the result side stalls, and lets the back end drain on its own schedule.
   logic                      queue_valid;
   logic                      queue_pop;
   rgbhsv_pkg::div_state_type queue_head;

   rgbhsv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_data  (front_work),
      .full       (req_full),
      .pop        (queue_pop),
      .head_valid (queue_valid),
      .head_data  (queue_head)
   );

   // The back end runs both divisions one quotient bit per stage, applies the
   // sector offset and truncation fix-up, and holds the result in an output
   // register until it is popped.
   rgbhsv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .work_valid     (queue_valid),
      .work           (queue_head),
      .work_take      (queue_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_value      (rsp_value)
   );

   // A black pixel always gives zero hue and zero saturation.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_value == 8'd0) |-> (rsp_hue == 16'sd0 && rsp_saturation == 16'd0))
      else $error("black pixel produced nonzero hue or saturation");

   // Saturation never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_saturation <= rgbhsv_pkg::SAT_ONE))
      else $error("saturation above one");

   // Hue stays within one sixth turn below zero and one full turn.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_hue >= -16'sd3840 && rsp_hue <= 16'sd23040))
      else $error("hue out of range");

   // Reset leaves both the intake and the result side empty.
   assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("block not empty after reset");

endmodule

`default_nettype wire

[sim/rgb_to_hsv_pixel_test.sv]
// Self-checking testbench for the RGB to HSV pixel converter.
`default_nettype none

module rgb_to_hsv_pixel_test;
   timeunit 1ns;
   timeprecision 1ps;

   // One converted pixel as it leaves the block on the rsp_ side.
   typedef struct packed {
      logic signed [15:0] hue;
      logic [15:0]        saturation;
      logic [7:0]         value;
   } hsv_result_type;

   // Cycles to let pass after the last result before a register write or the end.
   // The pipeline is 17 deep; the rest covers the intake queue.
   localparam int SETTLE_CYCLES = 24;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [7:0]         req_red = 8'd0;
   logic [7:0]         req_green = 8'd0;
   logic [7:0]         req_blue = 8'd0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic signed [15:0] rsp_hue;
   logic [15:0]        rsp_saturation;
   logic [7:0]         rsp_value;
   logic               csr_we = 1'b0;
   logic               csr_wdata = 1'b0;

   // Our own copy of the wrap mode register, tracked from the csr_ port.
   logic               wrap_model = 1'b1;
   // Converted pixels still owed by the block, oldest first.
   hsv_result_type     pending_hsv[$];
   hsv_result_type     oldest_hsv;
   int                 mismatch_count = 0;

   // Idle rates in percent; the phases of the random test change them.
   int unsigned        push_idle_pct = 0;
   int unsigned        pop_stall_pct = 0;

   rgb_to_hsv_pixel dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_value      (rsp_value),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Computes the expected hue, saturation and value of one pixel. All the
   // arithmetic is done in 32-bit signed integers so that the hue quotient
   // truncates toward zero, the same way the fixed-point divider must.
   function automatic hsv_result_type convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                                    input logic [7:0] b, input logic wrap);
      hsv_result_type res;
      int ri, gi, bi, hi, lo, span, num;
      ri = int'(r);
      gi = int'(g);
      bi = int'(b);
      hi = ri;
      lo = ri;
      if (gi > hi) hi = gi;
      if (bi > hi) hi = bi;
      if (gi < lo) lo = gi;
      if (bi < lo) lo = bi;
      span = hi - lo;
      res.value = hi[7:0];
      res.hue = '0;
      res.saturation = '0;
      // Black and grey pixels keep hue and saturation at zero.
      if (hi != 0 && span != 0) begin
         res.saturation = 16'((span * int'(rgbhsv_pkg::SAT_ONE)) / hi);
         // Red wins a tie for the largest channel, then green.
         if (ri == hi) begin
            num = int'(rgbhsv_pkg::HUE_SIXTY) * (gi - bi);
            if (num < 0 && wrap) num += int'(rgbhsv_pkg::HUE_FULL) * span;
         end else if (gi == hi) begin
            num = int'(rgbhsv_pkg::HUE_SECTOR_G) * span
                  + int'(rgbhsv_pkg::HUE_SIXTY) * (bi - ri);
         end else begin
            num = int'(rgbhsv_pkg::HUE_SECTOR_B) * span
                  + int'(rgbhsv_pkg::HUE_SIXTY) * (ri - gi);
         end
         res.hue = 16'(num / span);
      end
      return res;
   endfunction

   // Prints one line per mismatch and counts it.
   task automatic flag_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // The receiver pops at random; pop_stall_pct sets how often it holds back.
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   // Scoreboard. Everything is sampled at the rising edge, before any of this
   // edge's updates land, so the block and the testbench see the same values.
   // The result side is checked first, then a newly accepted pixel beat adds
   // its prediction, all in one process so that the queue never races.
   always @(posedge clock) begin
      if (reset) begin
         wrap_model <= 1'b1;
      end else begin
         if (csr_we) wrap_model <= csr_wdata;
         if (rsp_pop && !rsp_empty) begin
            if (pending_hsv.size() == 0) begin
               flag_mismatch($sformatf("result beat with nothing pending: hue %0d sat %0d val %0d",
                                       rsp_hue, rsp_saturation, rsp_value));
            end else begin
               oldest_hsv = pending_hsv.pop_front();
               if (rsp_hue !== oldest_hsv.hue)
                  flag_mismatch($sformatf("hue got %0d want %0d", rsp_hue, oldest_hsv.hue));
               if (rsp_saturation !== oldest_hsv.saturation)
                  flag_mismatch($sformatf("saturation got %0d want %0d",
                                          rsp_saturation, oldest_hsv.saturation));
               if (rsp_value !== oldest_hsv.value)
                  flag_mismatch($sformatf("value got %0d want %0d", rsp_value, oldest_hsv.value));
            end
         end
         if (req_push && !req_full)
            pending_hsv.insert(pending_hsv.size(),
                               convert_pixel(req_red, req_green, req_blue, wrap_model));
      end
   end

   // Sends one pixel beat. It is entered and left just after a rising edge.
   // The push line stays high from one beat to the next unless the sender
   // decides to idle, so it is never dropped and raised in the same step.
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      if ($urandom_range(99) < push_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < push_idle_pct);
      end
      req_push  <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      // The beat is taken at the first edge where the block is not full.
      do @(posedge clock); while (req_full);
   endtask

   // Waits until every owed result has come back and the pipeline has had
   // time to empty. The queue is looked at on falling edges so the scoreboard
   // has finished its work for the cycle.
   task automatic drain_pipeline();
      req_push <= 1'b0;
      while (pending_hsv.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only while the block is idle.
   task automatic write_wrap_mode(input logic wrap);
      drain_pipeline();
      csr_we    <= 1'b1;
      csr_wdata <= wrap;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Black, white and grey pixels: hue and saturation must stay at zero.
   task automatic test_black_and_grey();
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd1, 8'd1, 8'd1);
      send_pixel(8'd128, 8'd128, 8'd128);
   endtask

   // Each sector, the tie-breaks between channels and the red sector wrapping
   // around with the reset value of the wrap mode.
   task automatic test_sectors_with_wrap();
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);   // red and green tie, red wins
      send_pixel(8'd0, 8'd255, 8'd255);   // green and blue tie, green wins
      send_pixel(8'd255, 8'd0, 8'd255);   // red and blue tie, negative red hue
      send_pixel(8'd255, 8'd0, 8'd1);     // barely negative red hue
      send_pixel(8'd255, 8'd1, 8'd0);
      send_pixel(8'd0, 8'd1, 8'd255);
      send_pixel(8'd1, 8'd0, 8'd255);
      send_pixel(8'd254, 8'd255, 8'd0);   // green sector, blue below red
      send_pixel(8'd1, 8'd0, 8'd0);       // smallest nonzero value
      send_pixel(8'd255, 8'd254, 8'd254); // smallest spread at full value
   endtask

   // With wrap mode cleared a negative red hue must come out negative.
   task automatic test_wrap_disabled();
      write_wrap_mode(1'b0);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd200, 8'd10, 8'd199);
      send_pixel(8'd255, 8'd1, 8'd0);
   endtask

   // Random pixels in four idling phases, the wrap mode changing between them.
   // Greys, ties and channel extremes are mixed in with plain random pixels.
   task automatic test_random_phases();
      logic [7:0] r, g, b, hi, lo;
      int unsigned pick;
      for (int phase = 0; phase < 4; phase++) begin
         write_wrap_mode(phase % 2 == 0);
         case (phase)
            0: begin push_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin push_idle_pct = 51; pop_stall_pct = 0;  end
            2: begin push_idle_pct = 0;  pop_stall_pct = 51; end
            default: begin push_idle_pct = 14; pop_stall_pct = 14; end
         endcase
         for (int n = 0; n < 313; n++) begin
            case ($urandom_range(9))
               0: begin
                  r = 8'($urandom_range(255));
                  g = r;
                  b = r;
               end
               1: begin
                  // Two channels share the maximum, the third sits at or below it.
                  hi = 8'($urandom_range(255));
                  lo = 8'($urandom_range(hi));
                  pick = $urandom_range(2);
                  r = (pick == 0) ? lo : hi;
                  g = (pick == 1) ? lo : hi;
                  b = (pick == 2) ? lo : hi;
               end
               2: begin
                  r = ($urandom_range(1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(1));
                  g = ($urandom_range(1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(1));
                  b = ($urandom_range(1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(1));
               end
               default: begin
                  r = 8'($urandom_range(255));
                  g = 8'($urandom_range(255));
                  b = 8'($urandom_range(255));
               end
            endcase
            send_pixel(r, g, b);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_black_and_grey();
      test_sectors_with_wrap();
      test_wrap_disabled();
      test_random_phases();
      // Let the last results come home, then give any stray beat time to show up.
      drain_pipeline();
      if (pending_hsv.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", pending_hsv.size()));
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // The timeout leaves a wide margin over the length of a correct run.
   initial begin
      #1_000_000;
      $display("TIMEOUT: the run did not finish in time");
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
